// ===== rtl/kfb_pkg.sv =====
// Shared types, codes and constants of the K-line frame builder.
// Used by kfb_front, kfb_queue, kfb_back and kline_frame_builder.
// No dependencies.
package kfb_pkg;

  // Longest payload a frame may carry; longer counts are clamped.
  localparam int unsigned MAX_PAYLOAD = 63;
  localparam int unsigned POS_W = $clog2(MAX_PAYLOAD + 1);

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_SELECT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ISO9141_HEADER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ISO14230_HEADER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_IN_FMT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_CHECK_KIND  = 3'd4;

  // Frame format codes; the unused code behaves as raw.
  localparam logic [1:0] FMT_ISO9141  = 2'd0;
  localparam logic [1:0] FMT_ISO14230 = 2'd1;
  localparam logic [1:0] FMT_RAW      = 2'd2;

  // Raw checksum kinds.
  localparam logic [1:0] CK_NONE = 2'd0;
  localparam logic [1:0] CK_XOR  = 2'd1;
  localparam logic [1:0] CK_SUM  = 2'd2;
  localparam logic [1:0] CK_TWOS = 2'd3;

  // Reset values of the registers.
  localparam logic [1:0]  RST_FORMAT_SELECT   = FMT_ISO14230;
  localparam logic [23:0] RST_ISO9141_HEADER  = 24'h686AF1;
  localparam logic [23:0] RST_ISO14230_HEADER = 24'hC033F1;
  localparam logic        RST_LENGTH_IN_FMT   = 1'b1;
  localparam logic [1:0]  RST_RAW_CHECK_KIND  = CK_NONE;

  // Header byte count codes.
  localparam logic [2:0] NH_NONE  = 3'd0;
  localparam logic [2:0] NH_THREE = 3'd3;
  localparam logic [2:0] NH_FOUR  = 3'd4;

  // One classified request: everything the back end needs to emit its bytes.
  typedef struct packed {
    logic [3:0][7:0] hdr;        // header bytes, hdr[0] sent first
    logic [2:0]      nh;         // number of header bytes ahead of the payload
    logic [7:0]      payload;    // payload byte
    logic            last;       // payload byte ends the frame
    logic            send_check; // checksum byte follows the payload
    logic [7:0]      check;      // checksum byte
  } cmd_t;

endpackage

// ===== rtl/kline_frame_builder.sv =====
// Top level of the K-line transmit frame builder: front end, request queue
// and back end. Depends on kfb_pkg, kfb_front, kfb_queue and kfb_back.
//
// Channel | Direction | Content
// in_     | in        | tdata = payload_byte [7:0], payload_count [15:8]
// out_    | out       | tdata = line_byte [7:0], tuser = item_done, tlast = frame_done
// cfg_    | in        | index = register number, data = register value
//
// The output register sends one byte per cycle while the receiver takes them;
// a request produces 1 byte mid-frame, up to 5 at a frame start (4 header
// bytes and the payload), plus 1 when the checksum follows.
// The front end accepts a request per cycle while the two-entry queue has room.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled output holds its byte; the queue absorbs the front meanwhile.
module kline_frame_builder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // payload_byte, payload_count
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // line_byte
  output logic                           out_tuser, // item_done
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kfb_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;

  // Classification of requests.
  kfb_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_tvalid),
    .in_payload_byte  (in_tdata[7:0]),
    .in_payload_count (in_tdata[15:8]),
    .q_full           (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // Queue between front and back end.
  kfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Byte serializer and output register.
  kfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_item_done  (out_tuser),
    .out_frame_done (out_tlast)
  );

endmodule

// ===== rtl/kfb_front.sv =====
// Front end of the K-line frame builder: configuration registers, frame
// position and running checksum; classifies each request into a cmd_t.
// Depends on kfb_pkg.
module kfb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [kfb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kfb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic [7:0]                      in_payload_byte,
  input  logic [7:0]                      in_payload_count,
  input  logic                            q_full,
  output logic                            push,
  output kfb_pkg::cmd_t                   push_cmd
);
  import kfb_pkg::*;

  logic [1:0]       format_select_r;
  logic [23:0]      iso9141_header_r;
  logic [23:0]      iso14230_header_r;
  logic             length_in_fmt_r;
  logic [1:0]       raw_check_kind_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       acc_r, acc_nxt;

  logic [7:0]      len_c;
  logic            raw;
  logic            use_xor;
  logic            has_check;
  logic            first;
  logic [3:0][7:0] hb;
  logic [2:0]      nh;
  logic [7:0]      hsum;
  logic [7:0]      base;
  logic [7:0]      acc_new;
  logic [7:0]      pos_inc;
  logic            last;
  logic [7:0]      check;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_select_r   <= RST_FORMAT_SELECT;
      iso9141_header_r  <= RST_ISO9141_HEADER;
      iso14230_header_r <= RST_ISO14230_HEADER;
      length_in_fmt_r   <= RST_LENGTH_IN_FMT;
      raw_check_kind_r  <= RST_RAW_CHECK_KIND;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FORMAT_SELECT:   format_select_r   <= cfg_data[1:0];
        REG_ISO9141_HEADER:  iso9141_header_r  <= cfg_data[23:0];
        REG_ISO14230_HEADER: iso14230_header_r <= cfg_data[23:0];
        REG_LENGTH_IN_FMT:   length_in_fmt_r   <= cfg_data[0];
        REG_RAW_CHECK_KIND:  raw_check_kind_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Classify the request: header bytes, checksum and end of frame.
  always_comb begin
    if (in_payload_count == 8'd0) begin
      len_c = 8'd1;
    end else if (in_payload_count > 8'(MAX_PAYLOAD)) begin
      len_c = 8'(MAX_PAYLOAD);
    end else begin
      len_c = in_payload_count;
    end

    raw       = format_select_r[1];
    use_xor   = raw && (raw_check_kind_r == CK_XOR);
    has_check = !raw || (raw_check_kind_r != CK_NONE);
    first     = (pos_r == '0);

    hb = '0;
    nh = NH_NONE;
    if (first) begin
      if (format_select_r == FMT_ISO9141) begin
        hb[0] = iso9141_header_r[23:16];
        hb[1] = iso9141_header_r[15:8];
        hb[2] = iso9141_header_r[7:0];
        nh    = NH_THREE;
      end else if (format_select_r == FMT_ISO14230) begin
        hb[1] = iso14230_header_r[15:8];
        hb[2] = iso14230_header_r[7:0];
        if (length_in_fmt_r) begin
          hb[0] = iso14230_header_r[23:16] + len_c;
          nh    = NH_THREE;
        end else begin
          hb[0] = iso14230_header_r[23:16];
          hb[3] = len_c;
          nh    = NH_FOUR;
        end
      end
    end

    // A frame start restarts the checksum; header bytes are zero when absent.
    hsum    = hb[0] + hb[1] + hb[2] + hb[3];
    base    = first ? 8'd0 : acc_r;
    acc_new = use_xor ? (base ^ in_payload_byte) : (base + hsum + in_payload_byte);
    check   = (raw && (raw_check_kind_r == CK_TWOS)) ? (8'd0 - acc_new) : acc_new;

    pos_inc = {{(8 - POS_W){1'b0}}, pos_r} + 8'd1;
    last    = (pos_inc >= len_c);

    push                = in_valid && !q_full;
    push_cmd.hdr        = hb;
    push_cmd.nh         = nh;
    push_cmd.payload    = in_payload_byte;
    push_cmd.last       = last;
    push_cmd.send_check = last && has_check;
    push_cmd.check      = check;

    pos_nxt = pos_r;
    acc_nxt = acc_r;
    if (push) begin
      pos_nxt = last ? '0 : pos_inc[POS_W-1:0];
      acc_nxt = last ? 8'd0 : acc_new;
    end
  end

  // Frame position and running checksum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/kfb_queue.sv =====
// Two-entry queue of classified requests between front and back end.
// Depends on kfb_pkg.
module kfb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  kfb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output kfb_pkg::cmd_t head_cmd
);
  import kfb_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == 2'd2);
    head_valid = (cnt_r != 2'd0);
    head_cmd   = q_r[rd_ptr_r];
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Entry storage; written only at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> !pop) else $error("queue read while empty");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill level");
`endif

endmodule

// ===== rtl/kfb_back.sv =====
// K-line frame builder back end (depends on kfb_pkg): walks the bytes of
// the head request, one per cycle unless stalled, into the output register.
module kfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  kfb_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_item_done,
  output logic          out_frame_done
);
  import kfb_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_item_r;
  logic       out_frame_r;
  logic [2:0] idx_r, idx_nxt;

  logic       advance;
  logic       final_byte;
  logic [2:0] end_idx;
  logic [7:0] sel_byte;

  // Pick the byte at the current position of the head request.
  always_comb begin
    end_idx    = head_cmd.nh + {2'b00, head_cmd.send_check};
    final_byte = (idx_r == end_idx);
    if (idx_r < head_cmd.nh) begin
      sel_byte = head_cmd.hdr[idx_r[1:0]];
    end else if (idx_r == head_cmd.nh) begin
      sel_byte = head_cmd.payload;
    end else begin
      sel_byte = head_cmd.check;
    end

    advance = head_valid && (!out_valid_r || out_ready);
    pop     = advance && final_byte;

    idx_nxt = idx_r;
    if (advance) begin
      idx_nxt = final_byte ? 3'd0 : (idx_r + 3'd1);
    end

    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= sel_byte;
      out_item_r  <= final_byte;
      out_frame_r <= final_byte && head_cmd.last;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_item_done  = out_item_r;
  assign out_frame_done = out_frame_r;

`ifndef NO_ASSERTIONS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (idx_r <= end_idx)) else $error("byte position past request end");
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (idx_r == 3'd0)) else $error("byte position left without request");
  a_frame_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_r |-> out_item_r)
    else $error("frame end not on last byte of request");
`endif

endmodule

// ===== bench/tb_kline_frame_builder.sv =====
// Self-checking testbench for kline_frame_builder: streams payload requests under random
// idling and a long output hold-off, and checks every line byte against a frame predictor.
// Depends on kfb_pkg and the kline_frame_builder RTL.
module tb_kline_frame_builder;
  import kfb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned PHASE_ITEMS    = 16;
  localparam int unsigned RANDOM_PHASES  = 9;

  // Count sits above the payload byte, matching the in_tdata layout.
  typedef struct packed {
    logic [7:0] cnt;
    logic [7:0] pb;
  } payload_req_t;

  typedef struct packed {
    logic [7:0] line;
    logic       item_done;
    logic       frame_done;
  } line_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadows, starting at their reset values.
  logic [1:0]  fmt_r        = RST_FORMAT_SELECT;
  logic [23:0] hdr9141_r    = RST_ISO9141_HEADER;
  logic [23:0] hdr14230_r   = RST_ISO14230_HEADER;
  logic        len_in_fmt_r = RST_LENGTH_IN_FMT;
  logic [1:0]  raw_ck_r     = RST_RAW_CHECK_KIND;

  // Frame state of the predictor.
  logic [7:0] frame_pos = '0;
  logic [7:0] frame_sum = '0;

  payload_req_t requests_pending[$];
  line_beat_t   line_beats_due[$];
  line_beat_t   want_beat;

  logic        in_taken = 1'b0;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned bytes_seen = 0;
  int unsigned frames_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned phase_items = 0;

  kline_frame_builder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // payload_byte [7:0], payload_count [15:8]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // line_byte [7:0]
    .out_tuser  (out_tuser),   // item_done
    .out_tlast  (out_tlast),   // frame_done
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Clock with an 8 unit period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] fold_check(input logic [7:0] acc, input logic [7:0] b,
                                            input logic use_xor);
    return use_xor ? (acc ^ b) : (acc + b);
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic item, input logic frame);
    line_beat_t beat;
    beat.line = b;
    beat.item_done = item;
    beat.frame_done = frame;
    line_beats_due.push_back(beat);
  endtask

  // Works out the line bytes one accepted request causes and queues them.
  task automatic build_frame_bytes(input logic [7:0] pb, input logic [7:0] cnt);
    logic [7:0] eff;
    logic [7:0] hdr [4];
    logic [7:0] check;
    logic       is_raw;
    logic       use_xor;
    logic       has_check;
    logic       last;
    int         nh;
    int         k;
    eff = cnt;
    nh = 0;
    if (eff == 8'd0) eff = 8'd1;
    if (eff > MAX_PAYLOAD) eff = 8'(MAX_PAYLOAD);
    // The unused format code falls through to raw behavior.
    is_raw = (fmt_r != FMT_ISO9141) && (fmt_r != FMT_ISO14230);
    use_xor = is_raw && (raw_ck_r == CK_XOR);
    has_check = !is_raw || (raw_ck_r != CK_NONE);
    if (frame_pos == 8'd0) begin
      frame_sum = 8'd0;
      if (fmt_r == FMT_ISO9141) begin
        hdr[0] = hdr9141_r[23:16];
        hdr[1] = hdr9141_r[15:8];
        hdr[2] = hdr9141_r[7:0];
        nh = 3;
      end else if (fmt_r == FMT_ISO14230) begin
        hdr[0] = hdr14230_r[23:16];
        hdr[1] = hdr14230_r[15:8];
        hdr[2] = hdr14230_r[7:0];
        nh = 3;
        if (len_in_fmt_r) begin
          hdr[0] = hdr[0] + eff;
        end else begin
          hdr[3] = eff;
          nh = 4;
        end
      end
    end
    frame_pos = frame_pos + 8'd1;
    last = (frame_pos >= eff);
    for (k = 0; k < nh; k++) begin
      frame_sum = fold_check(frame_sum, hdr[k], use_xor);
      push_beat(hdr[k], 1'b0, 1'b0);
    end
    frame_sum = fold_check(frame_sum, pb, use_xor);
    if (!last) begin
      push_beat(pb, 1'b1, 1'b0);
    end else begin
      if (!has_check) begin
        push_beat(pb, 1'b1, 1'b1);
      end else begin
        check = frame_sum;
        if (is_raw && raw_ck_r == CK_TWOS) check = 8'h00 - frame_sum;
        push_beat(pb, 1'b0, 1'b0);
        push_beat(check, 1'b1, 1'b1);
      end
      frame_pos = 8'd0;
      frame_sum = 8'd0;
    end
  endtask

  // Request driver: holds a request until it is taken, otherwise may idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (requests_pending.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_tdata <= requests_pending.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, and nothing at all during a hold-off.
  always @(negedge clk) begin
    out_tready <= rst_n && (hold_left == 0) && ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Hold-off counter, loaded whenever a new hold-off has been asked for.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  // Monitor: predicts on accepted requests and checks accepted line bytes.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      build_frame_bytes(in_tdata[7:0], in_tdata[15:8]);
      requests_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      bytes_seen++;
      if (out_tlast) frames_seen++;
      if (line_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected line byte %02h item_done %0b frame_done %0b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want_beat = line_beats_due.pop_front();
        if (out_tdata !== want_beat.line || out_tuser !== want_beat.item_done ||
            out_tlast !== want_beat.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("line byte %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     bytes_seen, want_beat.line, want_beat.item_done,
                     want_beat.frame_done, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_FORMAT_SELECT:   fmt_r = val[1:0];
      REG_ISO9141_HEADER:  hdr9141_r = val;
      REG_ISO14230_HEADER: hdr14230_r = val;
      REG_LENGTH_IN_FMT:   len_in_fmt_r = val[0];
      REG_RAW_CHECK_KIND:  raw_ck_r = val[1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(input logic [1:0] fmt, input logic [23:0] h9141,
                         input logic [23:0] h14230, input logic lif, input logic [1:0] ck);
    write_reg(REG_FORMAT_SELECT, {22'd0, fmt});
    write_reg(REG_ISO9141_HEADER, h9141);
    write_reg(REG_ISO14230_HEADER, h14230);
    write_reg(REG_LENGTH_IN_FMT, {23'd0, lif});
    write_reg(REG_RAW_CHECK_KIND, {22'd0, ck});
  endtask

  task automatic push_req(input logic [7:0] pb, input logic [7:0] cnt);
    payload_req_t req;
    req.pb = pb;
    req.cnt = cnt;
    requests_pending.push_back(req);
    phase_items++;
  endtask

  // Waits until every request is taken and every byte has come out.
  task automatic drain();
    while (requests_pending.size() != 0 || in_tvalid || line_beats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_header();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 24'h000000;
    if (r == 1) return 24'hFFFFFF;
    return 24'($urandom());
  endfunction

  // One frame, mostly short; sometimes long, clamped, zero-count or plain noise.
  task automatic add_frame();
    int unsigned r;
    int unsigned n;
    int unsigned k;
    logic [7:0]  cnt;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      n = $urandom_range(1, 6);
      cnt = 8'(n);
    end else if (r < 80) begin
      n = $urandom_range(7, 20);
      cnt = 8'(n);
    end else if (r < 82) begin
      n = $urandom_range(21, 63);
      cnt = 8'(n);
    end else if (r < 84) begin
      n = MAX_PAYLOAD;
      cnt = 8'($urandom_range(64, 255));
    end else if (r < 89) begin
      n = 1;
      cnt = 8'd0;
    end else begin
      // Noise: counts that change from request to request.
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) push_req(8'($urandom()), 8'($urandom_range(0, 255)));
      return;
    end
    for (k = 0; k < n; k++) push_req(8'($urandom()), cnt);
  endtask

  initial begin
    int unsigned p;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 8;
    out_idle_pct = 51;

    // Reset settings: ISO14230 with length in the format byte.
    push_req(8'h00, 8'd1);
    push_req(8'hFF, 8'd0);     // zero count acts as one
    push_req(8'hA5, 8'd255);   // clamped length, then the count drops mid-frame
    push_req(8'h5A, 8'd2);
    push_req(8'h12, 8'd3);
    push_req(8'h34, 8'd3);
    push_req(8'h56, 8'd1);     // count below the bytes already sent ends the frame
    drain();

    set_all(FMT_ISO9141, 24'hFFFFFF, 24'h000000, 1'b0, CK_NONE);
    push_req(8'h80, 8'd2);
    push_req(8'h7F, 8'd2);
    drain();
    // Separate length byte, then the format byte wrapping past 0xFF.
    set_all(FMT_ISO14230, 24'h000000, 24'h000000, 1'b0, CK_NONE);
    push_req(8'h01, 8'd1);
    drain();
    set_all(FMT_ISO14230, 24'h000000, 24'hFFFFFF, 1'b1, CK_NONE);
    push_req(8'hFE, 8'd1);
    drain();
    set_all(FMT_RAW, 24'h000000, 24'h000000, 1'b0, CK_NONE);
    push_req(8'hAB, 8'd2);
    push_req(8'hCD, 8'd2);
    drain();
    set_all(FMT_RAW, 24'h000000, 24'h000000, 1'b1, CK_XOR);
    push_req(8'hF0, 8'd2);
    push_req(8'h0F, 8'd2);
    drain();
    set_all(FMT_RAW, 24'h000000, 24'h000000, 1'b1, CK_SUM);
    push_req(8'hFF, 8'd2);
    push_req(8'hFF, 8'd2);
    drain();
    // Unused format code with the two's complement checksum.
    set_all(2'd3, 24'hFFFFFF, 24'hFFFFFF, 1'b1, CK_TWOS);
    push_req(8'h00, 8'd1);
    push_req(8'h01, 8'd1);
    drain();

    // Random phases, each with its own register settings.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 3) begin
        in_idle_pct = 8;
        out_idle_pct = 51;
      end else if (p < 6) begin
        in_idle_pct = 51;
        out_idle_pct = 8;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      set_all(2'($urandom_range(0, 3)), pick_header(), pick_header(),
              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      // Hold the output off while requests keep coming, so the input backs up.
      if (p == 0) hold_requests++;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) add_frame();
      drain();
    end

    mismatches += line_beats_due.size();
    $display("covered %0d requests, %0d line bytes, %0d frames", requests_taken,
             bytes_seen, frames_seen);
    $display("with %0d register writes over all formats and checksum kinds", reg_writes);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kfb_pkg.sv
rtl/kfb_front.sv
rtl/kfb_queue.sv
rtl/kfb_back.sv
rtl/kline_frame_builder.sv
bench/tb_kline_frame_builder.sv
